[rtl/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache tag store:
// register map, reset values and the controller-to-datapath command group.
// ----------------------------------------------------------------------------
package salc_pkg;

   // register map, word index taken from paddr[3:2]
   localparam logic [1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [1:0] CSR_INDEX_BITS  = 2'd1;
   localparam logic [1:0] CSR_WAYS_IN_USE = 2'd2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CFG_W      = 4;

   localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd0;
   localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd8;
   localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = 4'd8;

   // widest set index taken from the address
   localparam int               IDX_W          = 12;
   localparam logic [CFG_W-1:0] MAX_INDEX_BITS = 4'd12;

   // fixed-point shift of the reciprocal used to fold the index onto the sets
   localparam int RECIP_SHIFT = 16;

   typedef struct packed {
      logic load_req;   // capture the accepted request
      logic calc_quot;  // register the folding quotient
      logic read_row;   // read the set row
      logic lookup;     // register hit, chosen way and age limit
      logic write_row;  // write the updated set row
      logic clear_row;  // clear valid bits and ages of one set
      logic load_rsp;   // load the result register
   } cmd_type;

endpackage

[rtl/salc_ctrl.sv]
// ----------------------------------------------------------------------------
// salc_ctrl
// Sequencing of the tag store: post-reset clearing sweep, then one access at
// a time through index folding, row read, lookup and row update.
// ----------------------------------------------------------------------------
module salc_ctrl
   import salc_pkg::*;
#(
   parameter int MAX_SETS = 256,
   parameter int SET_W    = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cmd_type          cmd,
   output logic [SET_W-1:0] clear_addr
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_READ,
      S_LOOKUP,
      S_UPDATE
   } state_type;

   localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

   state_type        state_ff;
   logic [SET_W-1:0] clear_cnt_ff;
   logic             rsp_valid_ff;
   logic             rsp_free;

   // result slot can take a new result this cycle
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign clear_addr = clear_cnt_ff;

   always_comb begin
      cmd           = '0;
      cmd.load_req  = (state_ff == S_IDLE) && req_valid;
      cmd.calc_quot = (state_ff == S_HASH);
      cmd.read_row  = (state_ff == S_READ);
      cmd.lookup    = (state_ff == S_LOOKUP);
      cmd.write_row = (state_ff == S_UPDATE) && rsp_free;
      cmd.load_rsp  = (state_ff == S_UPDATE) && rsp_free;
      cmd.clear_row = (state_ff == S_CLEAR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == S_UPDATE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clear_cnt_ff <= clear_cnt_ff + 1'b1;
               if (clear_cnt_ff == LAST_SET) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_HASH;
               end
            end
            S_HASH:   state_ff <= S_READ;
            S_READ:   state_ff <= S_LOOKUP;
            S_LOOKUP: state_ff <= S_UPDATE;
            S_UPDATE: begin
               if (rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/salc_dpath.sv]
// ----------------------------------------------------------------------------
// salc_dpath
// Tag store datapath: address split, index folding onto the sets, set row
// memories (valid bits, tags, ages), hit and victim search, age update.
// ----------------------------------------------------------------------------
module salc_dpath
   import salc_pkg::*;
#(
   parameter int MAX_SETS   = 256,
   parameter int MAX_WAYS   = 8,
   parameter int ADDR_WIDTH = 32,
   parameter int SET_W      = 8
) (
   input  logic             clock,
   input  cmd_type          cmd,
   input  logic [SET_W-1:0] clear_addr,
   input  logic [CFG_W-1:0] cfg_offset_bits,
   input  logic [CFG_W-1:0] cfg_index_bits,
   input  logic [CFG_W-1:0] cfg_ways_in_use,
   input  logic [31:0]      req_address,
   input  logic             req_last_access,
   output logic             rsp_hit,
   output logic             rsp_end_of_trace
);

   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W  = WAY_W;
   localparam int LIM_W   = RANK_W + 1;
   localparam int RECIP_W = RECIP_SHIFT + 1;
   localparam int PROD_W  = IDX_W + RECIP_W;
   localparam int REM_W   = IDX_W + 1;

   localparam logic [31:0]        ADDR_MASK = 32'((64'd1 << ADDR_WIDTH) - 64'd1);
   localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((1 << RECIP_SHIFT) / MAX_SETS);
   localparam logic [REM_W-1:0]   SETS_C    = REM_W'(MAX_SETS);
   localparam logic [RANK_W-1:0]  RANK_MAX  = RANK_W'(MAX_WAYS - 1);
   localparam logic [LIM_W-1:0]   LIM_ALL   = LIM_W'(MAX_WAYS);
   localparam logic [4:0]         WAYS_C    = 5'(MAX_WAYS);

   // set row memories
   logic [MAX_WAYS-1:0]                  valid_mem [MAX_SETS];
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tag_mem   [MAX_SETS];
   logic [MAX_WAYS-1:0][RANK_W-1:0]      rank_mem  [MAX_SETS];

   // request stage
   logic [ADDR_WIDTH-1:0] tag_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic                  last_ff;
   logic [MAX_WAYS-1:0]   use_ff;

   logic [31:0]           addr_m;
   logic [4:0]            tag_shift;
   logic [IDX_W-1:0]      idx_mask;
   logic [CFG_W-1:0]      ib_eff;
   logic [4:0]            ways_eff;
   logic [MAX_WAYS-1:0]   use_in;

   // index folding
   logic [IDX_W-1:0]  quot_ff;
   logic [PROD_W-1:0] quot_prod;
   logic [REM_W-1:0]  rem;
   logic [REM_W-1:0]  rem_fold;
   logic [SET_W-1:0]  set_idx;
   logic [SET_W-1:0]  set_ff;

   // row read data
   logic [MAX_WAYS-1:0]                 valid_rd_ff;
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_rd_ff;
   logic [MAX_WAYS-1:0][RANK_W-1:0]     rank_rd_ff;

   // lookup
   logic              hit_in;
   logic              have_free;
   logic [WAY_W-1:0]  hit_way;
   logic [WAY_W-1:0]  free_way;
   logic [WAY_W-1:0]  lru_way;
   logic [RANK_W-1:0] oldest;
   logic [WAY_W-1:0]  way_in;
   logic [LIM_W-1:0]  limit_in;
   logic              hit_ff;
   logic [WAY_W-1:0]  way_ff;
   logic [LIM_W-1:0]  limit_ff;

   // row update
   logic [MAX_WAYS-1:0]                 valid_wr;
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_wr;
   logic [MAX_WAYS-1:0][RANK_W-1:0]     rank_wr;

   logic rsp_hit_ff;
   logic rsp_eot_ff;

   // address split on the incoming request
   always_comb begin
      addr_m    = req_address & ADDR_MASK;
      ib_eff    = (cfg_index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : cfg_index_bits;
      tag_shift = 5'(ib_eff) + 5'(cfg_offset_bits);
      idx_mask  = (IDX_W'(1) << ib_eff) - IDX_W'(1);
      if (cfg_ways_in_use == '0) begin
         ways_eff = 5'd1;
      end else if (5'(cfg_ways_in_use) > WAYS_C) begin
         ways_eff = WAYS_C;
      end else begin
         ways_eff = 5'(cfg_ways_in_use);
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         use_in[i] = (5'(i) < ways_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         tag_ff  <= ADDR_WIDTH'(addr_m >> tag_shift);
         idx_ff  <= IDX_W'(addr_m >> cfg_offset_bits) & idx_mask;
         last_ff <= req_last_access;
         use_ff  <= use_in;
      end
   end

   // fold the index onto the sets: estimate by reciprocal, then one correction
   assign quot_prod = PROD_W'(idx_ff) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (cmd.calc_quot) begin
         quot_ff <= quot_prod[RECIP_SHIFT +: IDX_W];
      end
   end

   always_comb begin
      rem      = REM_W'(idx_ff) - REM_W'(25'(quot_ff) * 25'(MAX_SETS));
      rem_fold = (rem >= SETS_C) ? (rem - SETS_C) : rem;
      set_idx  = rem_fold[SET_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.read_row) begin
         set_ff <= set_idx;
      end
   end

   // memories: one row read or one row write per cycle
   always_ff @(posedge clock) begin
      if (cmd.clear_row) begin
         valid_mem[clear_addr] <= '0;
      end else if (cmd.write_row) begin
         valid_mem[set_ff] <= valid_wr;
      end
      if (cmd.read_row) begin
         valid_rd_ff <= valid_mem[set_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_row) begin
         rank_mem[clear_addr] <= '0;
      end else if (cmd.write_row) begin
         rank_mem[set_ff] <= rank_wr;
      end
      if (cmd.read_row) begin
         rank_rd_ff <= rank_mem[set_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_row) begin
         tag_mem[set_ff] <= tag_wr;
      end
      if (cmd.read_row) begin
         tag_rd_ff <= tag_mem[set_idx];
      end
   end

   // hit, first free way and least recently used way among ways in use
   always_comb begin
      hit_in    = 1'b0;
      have_free = 1'b0;
      hit_way   = '0;
      free_way  = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (use_ff[i] && valid_rd_ff[i] && (tag_rd_ff[i] == tag_ff)) begin
            hit_in  = 1'b1;
            hit_way = WAY_W'(i);
         end
         if (use_ff[i] && !valid_rd_ff[i]) begin
            have_free = 1'b1;
            free_way  = WAY_W'(i);
         end
      end
      oldest  = rank_rd_ff[0];
      lru_way = '0;
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (use_ff[i] && (rank_rd_ff[i] > oldest)) begin
            oldest  = rank_rd_ff[i];
            lru_way = WAY_W'(i);
         end
      end
      if (hit_in) begin
         way_in   = hit_way;
         limit_in = LIM_W'(rank_rd_ff[hit_way]);
      end else if (have_free) begin
         way_in   = free_way;
         limit_in = LIM_ALL;
      end else begin
         way_in   = lru_way;
         limit_in = LIM_W'(oldest);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff   <= hit_in;
         way_ff   <= way_in;
         limit_ff <= limit_in;
      end
   end

   // chosen way becomes youngest, younger valid ways age by one
   always_comb begin
      valid_wr = valid_rd_ff;
      tag_wr   = tag_rd_ff;
      rank_wr  = rank_rd_ff;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WAY_W'(i) == way_ff) begin
            rank_wr[i]  = '0;
            valid_wr[i] = 1'b1;
            if (!hit_ff) begin
               tag_wr[i] = tag_ff;
            end
         end else if (valid_rd_ff[i] && (LIM_W'(rank_rd_ff[i]) < limit_ff)
                      && (rank_rd_ff[i] < RANK_MAX)) begin
            rank_wr[i] = rank_rd_ff[i] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_hit_ff <= hit_ff;
         rsp_eot_ff <= last_ff;
      end
   end

   assign rsp_hit          = rsp_hit_ff;
   assign rsp_end_of_trace = rsp_eot_ff;

endmodule

[rtl/set_assoc_lru_cache_tags.sv]
// A result is registered after its request passes capture, index fold, row read,
// lookup and row update over a single-port set row memory; the update waits while
// a held result is stalled, and a new request is taken only after the row update.
// The result register holds a finished result while the next request is taken.
// Reset: synchronous; afterwards a clearing sweep over the MAX_SETS sets resets the
// valid bits and ages of every set, during which req_stall stays high.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag store of a set-associative cache with least-recently-used replacement,
// with an APB-style register port for offset bits, index bits and ways in use.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags
   import salc_pkg::*;
#(
   parameter int MAX_SETS   = 256,
   parameter int MAX_WAYS   = 8,
   parameter int ADDR_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [31:0]           req_address,
   input  logic                  req_last_access,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_hit,
   output logic                  rsp_end_of_trace,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

   logic [CFG_W-1:0] offset_bits_ff;
   logic [CFG_W-1:0] index_bits_ff;
   logic [CFG_W-1:0] ways_in_use_ff;
   logic             csr_wr;
   logic [1:0]       csr_reg;
   cmd_type          cmd;
   logic [SET_W-1:0] clear_addr;

   assign csr_pready = 1'b1;
   assign csr_reg    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OFFSET_BITS_RST;
         index_bits_ff  <= INDEX_BITS_RST;
         ways_in_use_ff <= WAYS_IN_USE_RST;
      end else if (csr_wr) begin
         unique case (csr_reg)
            CSR_OFFSET_BITS: offset_bits_ff <= csr_pwdata[CFG_W-1:0];
            CSR_INDEX_BITS:  index_bits_ff  <= csr_pwdata[CFG_W-1:0];
            CSR_WAYS_IN_USE: ways_in_use_ff <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         CSR_OFFSET_BITS: csr_prdata = CSR_DATA_W'(offset_bits_ff);
         CSR_INDEX_BITS:  csr_prdata = CSR_DATA_W'(index_bits_ff);
         CSR_WAYS_IN_USE: csr_prdata = CSR_DATA_W'(ways_in_use_ff);
         default:         csr_prdata = '0;
      endcase
   end

   salc_ctrl #(
      .MAX_SETS (MAX_SETS),
      .SET_W    (SET_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .clear_addr (clear_addr)
   );

   salc_dpath #(
      .MAX_SETS   (MAX_SETS),
      .MAX_WAYS   (MAX_WAYS),
      .ADDR_WIDTH (ADDR_WIDTH),
      .SET_W      (SET_W)
   ) u_dpath (
      .clock            (clock),
      .cmd              (cmd),
      .clear_addr       (clear_addr),
      .cfg_offset_bits  (offset_bits_ff),
      .cfg_index_bits   (index_bits_ff),
      .cfg_ways_in_use  (ways_in_use_ff),
      .req_address      (req_address),
      .req_last_access  (req_last_access),
      .rsp_hit          (rsp_hit),
      .rsp_end_of_trace (rsp_end_of_trace)
   );

endmodule
